// ===== rtl/hmad_pkg.sv =====
// Shared types and constants of the histogram median and absolute deviation block.
package hmad_pkg;

	// Saturation limit of the absolute deviation sum.
	localparam int unsigned SumW = 24;
	localparam logic [SumW-1:0] SUM_LIMIT = {SumW{1'b1}};

	// Width of the median output port.
	localparam int unsigned MedW = 8;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DRAIN,
		S_MED,
		S_MED_END,
		S_DEV,
		S_DEV_END1,
		S_DEV_END2,
		S_EMIT
	} hmad_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic med_init;
		logic med_scan;
		logic dev_init;
		logic dev_scan;
		logic clear;
	} hmad_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
	} hmad_stat_t;

endpackage

// ===== rtl/hmad_ctrl.sv =====
// Controller state machine of the histogram median and absolute deviation block.
module hmad_ctrl #(
	parameter int BINS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 last,
	output logic                 busy,
	output logic                 done,
	output hmad_pkg::hmad_cmd_t  cmd,
	input  hmad_pkg::hmad_stat_t stat
);
	import hmad_pkg::*;

	hmad_state_t state_q;
	hmad_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
				if (start && last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// The last sample finishes its count update here.
				cmd.med_init = 1'b1;
				state_d      = S_MED;
			end
			S_MED: begin
				cmd.med_scan = 1'b1;
				if (stat.scan_last) begin
					state_d = S_MED_END;
				end
			end
			S_MED_END: begin
				// The last bin of the median walk is evaluated here.
				cmd.dev_init = 1'b1;
				state_d      = S_DEV;
			end
			S_DEV: begin
				cmd.dev_scan = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DEV_END1;
				end
			end
			S_DEV_END1: begin
				state_d = S_DEV_END2;
			end
			S_DEV_END2: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				done      = 1'b1;
				cmd.clear = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The result strobe lasts exactly one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A closing request yields its result after both walks.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last) |-> ##(2*BINS+5) done)
		else $error("result not delivered at the expected cycle");

	// No request is taken while a set is being evaluated.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.accept)
		else $error("request accepted while busy");

endmodule

// ===== rtl/hmad_dpath.sv =====
// Datapath of the histogram median and absolute deviation block: bin memory and walks.
module hmad_dpath #(
	parameter int BINS        = 256,
	parameter int MAX_SAMPLES = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hmad_pkg::hmad_cmd_t       cmd,
	output hmad_pkg::hmad_stat_t      stat,
	input  logic [7:0]                sample,
	input  logic                      has_sample,
	output logic [hmad_pkg::MedW-1:0] median,
	output logic [hmad_pkg::SumW-1:0] abs_dev_sum,
	output logic                      overflow
);
	import hmad_pkg::*;

	localparam int IW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int PW = IW + CW;
	localparam int AW = ((PW > SumW) ? PW : SumW) + 1;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_SAMPLES);
	localparam logic [IW-1:0] LAST_BIN = IW'(BINS - 1);

	// Bin memory, with one valid bit per bin so a whole set clears at once.
	logic [CW-1:0]   mem [BINS];
	logic [BINS-1:0] vld_q;

	logic [CW-1:0] total_q;
	logic          drop_q;
	logic [IW-1:0] scan_q;

	logic [IW-1:0] rd_addr;
	logic          in_range;
	logic          inc;

	logic [CW-1:0] rdata_s1;
	logic          vbit_s1;
	logic [IW-1:0] idx_s1;
	logic          inc_s1;
	logic          med_s1;
	logic          dev_s1;

	logic          wr_q;
	logic [IW-1:0] wr_addr_q;
	logic [CW-1:0] wr_data_q;

	logic [CW-1:0] cnt_s1;
	logic [CW-1:0] new_cnt;

	logic [CW-1:0] run_q;
	logic          found_q;
	logic          need_q;
	logic [IW-1:0] medi_q;
	logic [IW-1:0] med_q;
	logic [CW:0]   half;
	logic [CW:0]   runc;
	logic [IW:0]   mid_sum;

	logic [IW-1:0] bin_gap;
	logic [PW-1:0] prod_s2;
	logic          dev_s2;
	logic [SumW-1:0] acc_q;
	logic [AW-1:0] acc_sum;

	// A sample is counted if it falls inside the bins and the set is not full.
	assign in_range = {1'b0, sample} < 9'(BINS);
	assign inc      = cmd.accept && has_sample && in_range && (total_q < MAX_C);
	assign rd_addr  = cmd.accept ? sample[IW-1:0] : scan_q;

	// Memory read port, shared by the count update and the walks.
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_addr];
		vbit_s1  <= vld_q[rd_addr];
		idx_s1   <= rd_addr;
	end

	// Stage flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s1 <= 1'b0;
			med_s1 <= 1'b0;
			dev_s1 <= 1'b0;
			dev_s2 <= 1'b0;
			wr_q   <= 1'b0;
		end else begin
			inc_s1 <= inc;
			med_s1 <= cmd.med_scan;
			dev_s1 <= cmd.dev_scan;
			dev_s2 <= dev_s1;
			wr_q   <= inc_s1;
		end
	end

	// Count of the bin in stage one, forwarded from the write just made.
	always_comb begin
		if (inc_s1 && wr_q && (wr_addr_q == idx_s1)) begin
			cnt_s1 = wr_data_q;
		end else if (vbit_s1) begin
			cnt_s1 = rdata_s1;
		end else begin
			cnt_s1 = '0;
		end
	end
	assign new_cnt = cnt_s1 + CW'(1);

	// Memory write port.
	always_ff @(posedge clk) begin
		if (inc_s1) begin
			mem[idx_s1] <= new_cnt;
		end
		wr_addr_q <= idx_s1;
		wr_data_q <= new_cnt;
	end

	// Valid bits, total count and drop flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			total_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.clear) begin
			vld_q   <= '0;
			total_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			if (inc_s1) begin
				vld_q[idx_s1] <= 1'b1;
			end
			if (inc) begin
				total_q <= total_q + CW'(1);
			end else if (cmd.accept && has_sample && in_range) begin
				drop_q <= 1'b1;
			end
		end
	end

	// Walk address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.med_init || cmd.dev_init) begin
			scan_q <= '0;
		end else if (cmd.med_scan || cmd.dev_scan) begin
			scan_q <= scan_q + IW'(1);
		end
	end
	assign stat.scan_last = (scan_q == LAST_BIN);

	// Median walk: half-count bin; on an exact even split, mean with the next used bin.
	assign half    = ({1'b0, total_q} + (CW+1)'(1)) >> 1;
	assign runc    = {1'b0, run_q} + {1'b0, cnt_s1};
	assign mid_sum = {1'b0, medi_q} + {1'b0, idx_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			found_q <= 1'b0;
			need_q  <= 1'b0;
			medi_q  <= '0;
			med_q   <= '0;
		end else if (cmd.med_init) begin
			run_q   <= '0;
			found_q <= 1'b0;
			need_q  <= 1'b0;
			medi_q  <= '0;
			med_q   <= '0;
		end else if (med_s1) begin
			if (!found_q) begin
				run_q <= runc[CW-1:0];
				if (runc >= half) begin
					found_q <= 1'b1;
					medi_q  <= idx_s1;
					med_q   <= idx_s1;
					need_q  <= (runc == half) && !total_q[0];
				end
			end else if (need_q && (cnt_s1 != '0)) begin
				need_q <= 1'b0;
				med_q  <= mid_sum[IW:1];
			end
		end
	end

	// Deviation walk: distance times count, registered before accumulation.
	assign bin_gap = (idx_s1 >= med_q) ? (idx_s1 - med_q) : (med_q - idx_s1);

	always_ff @(posedge clk) begin
		prod_s2 <= PW'(bin_gap) * PW'(cnt_s1);
	end

	// Saturating accumulator.
	assign acc_sum = AW'(acc_q) + AW'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.dev_init) begin
			acc_q <= '0;
		end else if (dev_s2) begin
			if (acc_sum > AW'(SUM_LIMIT)) begin
				acc_q <= SUM_LIMIT;
			end else begin
				acc_q <= acc_sum[SumW-1:0];
			end
		end
	end

	assign median      = MedW'(med_q);
	assign abs_dev_sum = acc_q;
	assign overflow    = drop_q;

	// No count update may overlap a walk.
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		inc_s1 |-> !(med_s1 || dev_s1))
		else $error("count update during a bin walk");

	// The two walks never overlap.
	a_walks_apart: assert property (@(posedge clk) disable iff (!arst_n)
		med_s1 |-> !(dev_s1 || dev_s2))
		else $error("median and deviation walks overlap");

	// Closing a set empties the histogram.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (total_q == '0) && !drop_q && (vld_q == '0))
		else $error("histogram not cleared after a result");

endmodule

// ===== rtl/histogram_median_abs_deviation.sv =====
// Top level of the histogram median and absolute deviation block.
// Samples are counted into a histogram of BINS bins at one request per cycle; a request
// with last set closes the set and raises busy until the result has been given, as the
// single read port of the bin memory serves the median walk and then the deviation walk,
// each stepping through one bin per cycle. The result appears on median, abs_dev_sum and
// overflow for exactly one cycle with done high, once both walks are through; the
// receiver cannot stall it. The histogram is then empty again.
module histogram_median_abs_deviation #(
	parameter int BINS        = 256,
	parameter int MAX_SAMPLES = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [7:0]                sample,
	input  logic                      has_sample,
	input  logic                      last,
	output logic                      done,
	output logic [hmad_pkg::MedW-1:0] median,
	output logic [hmad_pkg::SumW-1:0] abs_dev_sum,
	output logic                      overflow
);
	import hmad_pkg::*;

	hmad_cmd_t  cmd;
	hmad_stat_t stat;

	// Sequencer of the count updates and the two walks.
	hmad_ctrl #(
		.BINS (BINS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Bin memory, median search and deviation sum.
	hmad_dpath #(
		.BINS        (BINS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.sample      (sample),
		.has_sample  (has_sample),
		.median      (median),
		.abs_dev_sum (abs_dev_sum),
		.overflow    (overflow)
	);

endmodule
